FILE: rtl/fsk_ser_pkg.sv
package fsk_ser_pkg;

   // Width of the tick and cycle counters.
   localparam int COUNT_WIDTH = 12;
   // Width of every configuration register.
   localparam int REG_WIDTH = 12;
   localparam int BYTE_WIDTH = 8;
   localparam int INDEX_WIDTH = $clog2(BYTE_WIDTH);

   typedef logic [COUNT_WIDTH-1:0] count_type;
   typedef logic [REG_WIDTH-1:0] reg_type;
   typedef logic [BYTE_WIDTH-1:0] byte_type;
   typedef logic [INDEX_WIDTH-1:0] index_type;
   // One bit wider than the position count so that "past the last bit" fits.
   typedef logic [INDEX_WIDTH:0] from_type;

   // Input word kinds.
   localparam logic KIND_TICK = 1'b0;
   localparam logic KIND_LOAD = 1'b1;

   // Register reset values.
   localparam reg_type MARK_HALF_RESET = REG_WIDTH'(8);
   localparam reg_type MARK_CYCLES_RESET = REG_WIDTH'(12);
   localparam reg_type SPACE_HALF_RESET = REG_WIDTH'(4);
   localparam reg_type SPACE_CYCLES_RESET = REG_WIDTH'(25);

   typedef enum logic [1:0] {
      CSR_MARK_HALF_TICKS  = 2'd0,
      CSR_MARK_CYCLES      = 2'd1,
      CSR_SPACE_HALF_TICKS = 2'd2,
      CSR_SPACE_CYCLES     = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic     kind;
      byte_type data_byte;
   } req_type;

   typedef struct packed {
      logic pin_level;
      logic busy_res;
      logic byte_done;
      logic rejected;
   } rsp_type;

   typedef struct packed {
      reg_type mark_half_ticks;
      reg_type mark_cycles;
      reg_type space_half_ticks;
      reg_type space_cycles;
   } cfg_type;

   typedef struct packed {
      logic      found;
      index_type idx;
   } pick_type;

   // Lowest bit position at or after 'from' whose tone has a nonzero cycle count.
   function automatic pick_type first_bit(input byte_type data,
                                          input logic mark_nz,
                                          input logic space_nz,
                                          input from_type from);
      pick_type pick;
      logic     elig;
      pick = '0;
      for (int i = BYTE_WIDTH - 1; i >= 0; i--) begin
         elig = data[i] ? mark_nz : space_nz;
         if (elig && (from_type'(i) >= from)) begin
            pick.found = 1'b1;
            pick.idx   = index_type'(i);
         end
      end
      return pick;
   endfunction

endpackage

FILE: rtl/fsk_ser_engine.sv
module fsk_ser_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  fsk_ser_pkg::req_type req,
   input  fsk_ser_pkg::cfg_type cfg,
   output fsk_ser_pkg::rsp_type result
);
   import fsk_ser_pkg::*;

   localparam int CMP_WIDTH = ((COUNT_WIDTH > REG_WIDTH) ? COUNT_WIDTH : REG_WIDTH) + 1;

   byte_type  shift_byte_ff, shift_byte_in;
   index_type bit_index_ff, bit_index_in;
   count_type tick_count_ff, tick_count_in;
   count_type cycles_left_ff, cycles_left_in;
   logic      high_phase_ff, high_phase_in;
   logic      active_ff, active_in;

   logic      mark_nz;
   logic      space_nz;
   logic      cur_bit;
   reg_type   half;
   logic      phase_end;
   count_type cycles_dec;
   byte_type  scan_byte;
   from_type  scan_from;
   logic      scan_go;
   pick_type  pick;
   logic      done;
   logic      rej;

   assign mark_nz  = count_type'(cfg.mark_cycles) != '0;
   assign space_nz = count_type'(cfg.space_cycles) != '0;
   assign cur_bit  = shift_byte_ff[bit_index_ff];

   always_comb begin
      half = cur_bit ? cfg.mark_half_ticks : cfg.space_half_ticks;
      if (half == '0) begin
         half = REG_WIDTH'(1);
      end
   end

   assign phase_end  = (CMP_WIDTH'(tick_count_ff) + CMP_WIDTH'(1)) >= CMP_WIDTH'(half);
   assign cycles_dec = cycles_left_ff - COUNT_WIDTH'(1);

   // Either a fresh byte from position zero or the held byte past the bit just sent.
   assign scan_byte = (req.kind == KIND_LOAD) ? req.data_byte : shift_byte_ff;
   assign scan_from = (req.kind == KIND_LOAD) ? '0 : ({1'b0, bit_index_ff} + from_type'(1));
   assign pick      = first_bit(scan_byte, mark_nz, space_nz, scan_from);

   always_comb begin
      shift_byte_in  = shift_byte_ff;
      bit_index_in   = bit_index_ff;
      tick_count_in  = tick_count_ff;
      cycles_left_in = cycles_left_ff;
      high_phase_in  = high_phase_ff;
      active_in      = active_ff;
      scan_go        = 1'b0;
      rej            = 1'b0;

      if (req.kind == KIND_LOAD) begin
         if (active_ff) begin
            rej = 1'b1;
         end else begin
            shift_byte_in = req.data_byte;
            scan_go       = 1'b1;
         end
      end else if (active_ff) begin
         if (phase_end) begin
            tick_count_in = '0;
            if (high_phase_ff) begin
               high_phase_in = 1'b0;
            end else if (cycles_dec != '0) begin
               cycles_left_in = cycles_dec;
               high_phase_in  = 1'b1;
            end else begin
               scan_go = 1'b1;
            end
         end else begin
            tick_count_in = tick_count_ff + COUNT_WIDTH'(1);
         end
      end

      // Start the next bit that has cycles to send, or finish the byte.
      if (scan_go) begin
         tick_count_in = '0;
         if (pick.found) begin
            bit_index_in   = pick.idx;
            cycles_left_in = scan_byte[pick.idx] ? count_type'(cfg.mark_cycles)
                                                 : count_type'(cfg.space_cycles);
            high_phase_in  = 1'b1;
            active_in      = 1'b1;
         end else begin
            bit_index_in   = '0;
            cycles_left_in = '0;
            high_phase_in  = 1'b0;
            active_in      = 1'b0;
         end
      end

      done = scan_go && !pick.found;
   end

   assign result.pin_level = active_in && high_phase_in;
   assign result.busy_res  = active_in;
   assign result.byte_done = done;
   assign result.rejected  = rej;

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_byte_ff  <= '0;
         bit_index_ff   <= '0;
         tick_count_ff  <= '0;
         cycles_left_ff <= '0;
         high_phase_ff  <= 1'b0;
         active_ff      <= 1'b0;
      end else if (step) begin
         shift_byte_ff  <= shift_byte_in;
         bit_index_ff   <= bit_index_in;
         tick_count_ff  <= tick_count_in;
         cycles_left_ff <= cycles_left_in;
         high_phase_ff  <= high_phase_in;
         active_ff      <= active_in;
      end
   end

`ifndef SYNTH
   // An idle block never holds the pin high.
   a_idle_low: assert property (@(posedge clock) disable iff (reset)
      !active_ff |-> !high_phase_ff)
      else $error("high phase while idle");

   // A bit in progress always has at least one cycle left.
   a_cycles_live: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (cycles_left_ff != '0))
      else $error("active with no cycles left");

   // A load taken while sending is dropped and leaves the byte untouched.
   a_reject_holds: assert property (@(posedge clock) disable iff (reset)
      (step && req.kind == KIND_LOAD && active_ff) |=> $stable(shift_byte_ff))
      else $error("rejected load changed the byte");
`endif

endmodule

FILE: rtl/fsk_tone_bit_serializer.sv
// Binary FSK square-wave serializer.
// The req channel carries words of two kinds: a tick, one per 0.1 ms of
// tone time, and a load that hands over a byte. A loaded byte goes out least
// significant bit first; each bit is a burst of square-wave cycles at the
// mark (1) or space (0) half-period, high then low for one half-period each.
// Every req word yields exactly one rsp word with the pin level, the busy
// flag, a done strobe when the last bit ends or a load has no bit to send,
// and a reject flag for a load that arrives while a byte is still being sent.
// rsp_valid rises in the cycle after acceptance, and one word is taken every
// cycle while req_stall is low: the whole state update is a single pass of
// logic ahead of the rsp output register, which doubles as the holding stage
// while rsp_stall is high. req_stall rises only when that register is full
// and stalled. The csr port writes the four timing registers; it is always
// ready and is meant to be used while the block is idle. Synchronous reset
// restores the register defaults, clears the sender to idle with the pin low,
// and empties the output register.
module fsk_tone_bit_serializer (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  fsk_ser_pkg::req_type       req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output fsk_ser_pkg::rsp_type       rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  fsk_ser_pkg::csr_index_type csr_index,
   input  fsk_ser_pkg::reg_type       csr_wdata
);
   import fsk_ser_pkg::*;

   cfg_type cfg_ff;
   logic    rsp_valid_ff;
   rsp_type rsp_ff;
   logic    req_take;
   rsp_type result;

   // The output register can always take a new word unless it is full and
   // the receiver is holding it.
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mark_half_ticks  <= MARK_HALF_RESET;
         cfg_ff.mark_cycles      <= MARK_CYCLES_RESET;
         cfg_ff.space_half_ticks <= SPACE_HALF_RESET;
         cfg_ff.space_cycles     <= SPACE_CYCLES_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_MARK_HALF_TICKS:  cfg_ff.mark_half_ticks  <= csr_wdata;
            CSR_MARK_CYCLES:      cfg_ff.mark_cycles      <= csr_wdata;
            CSR_SPACE_HALF_TICKS: cfg_ff.space_half_ticks <= csr_wdata;
            CSR_SPACE_CYCLES:     cfg_ff.space_cycles     <= csr_wdata;
            default: ;
         endcase
      end
   end

   fsk_ser_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .step   (req_take),
      .req    (req_data),
      .cfg    (cfg_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
